// ===== rtl/core/olist_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types, request and status codes for the ordered list engine.
// ----------------------------------------------------------------------------
package olist_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int REQ_W      = 3;
    localparam int POS_W      = 5;
    localparam int ITEM_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int FPOS_W     = 4;
    localparam int CNT_OUT_W  = 5;

    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FIND   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic [POS_W-1:0]         position;
        logic signed [ITEM_W-1:0] item_value;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [ITEM_W-1:0] read_value;
        logic [FPOS_W-1:0]        found_position;
        logic [CNT_OUT_W-1:0]     entry_count;
    } result_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } cell_cmd_t;

endpackage

// ===== rtl/core/olist_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_cell
// One list slot: holds a value, shifts it to or takes it from a neighbor,
// and registers whether it equals the search key.
// ----------------------------------------------------------------------------
module olist_cell #(
    parameter int VALUE_WIDTH = olist_pkg::VALUE_WIDTH_DEF,
    parameter int IDX_W       = 4,
    parameter int CELL_IDX    = 0
) (
    input  logic                    clk,
    input  olist_pkg::cell_cmd_t    cmd,
    input  logic [IDX_W-1:0]        pos,
    input  logic [VALUE_WIDTH-1:0]  item,
    input  logic [VALUE_WIDTH-1:0]  left_value,
    input  logic [VALUE_WIDTH-1:0]  right_value,
    output logic [VALUE_WIDTH-1:0]  value,
    output logic                    match
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [VALUE_WIDTH-1:0] data_reg;
    logic [VALUE_WIDTH-1:0] data_next;
    logic                   match_reg;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.shift_up)
        begin
            // slots past the insert point take the lower neighbor's word
            if (MY_IDX > pos)
            begin
                data_next = left_value;
            end
            else if (MY_IDX == pos)
            begin
                data_next = item;
            end
        end
        else if (cmd.shift_down)
        begin
            if (MY_IDX >= pos)
            begin
                data_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= (data_reg == item);
    end

    assign value = data_reg;
    assign match = match_reg;

endmodule

// ===== rtl/core/olist_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_ctrl
// Request sequencer: decodes a word, drives the cell chain, keeps the entry
// count and builds the result word.
// ----------------------------------------------------------------------------
module olist_ctrl #(
    parameter int DEPTH       = olist_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = olist_pkg::VALUE_WIDTH_DEF,
    parameter int IDX_W       = 4,
    parameter int CNT_W       = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  olist_pkg::request_t     request,
    output logic                    done,
    output olist_pkg::result_t      result,
    output olist_pkg::cell_cmd_t    cmd,
    output logic [IDX_W-1:0]        cmd_pos,
    output logic [VALUE_WIDTH-1:0]  item,
    input  logic [VALUE_WIDTH-1:0]  cell_value [DEPTH],
    input  logic [DEPTH-1:0]        cell_match
);

    import olist_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic                exec_reg;
    logic                resp_reg;
    logic                done_reg;
    request_t            req_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [ITEM_W-1:0]   rd_reg;
    logic [ITEM_W-1:0]   rd_next;
    logic                find_reg;
    result_t             result_reg;
    result_t             result_next;

    logic                accept;
    logic [CMP_W-1:0]    pos_x;
    logic [CMP_W-1:0]    cnt_x;
    logic [CMP_W-1:0]    ins_x;
    logic                full;
    logic                hit;
    logic [IDX_W-1:0]    fpos;

    assign accept = start & ~exec_reg;
    assign item   = VALUE_WIDTH'($signed(req_reg.item_value));

    // execute cycle: decide the cell operation, status and new count
    always_comb
    begin
        pos_x       = CMP_W'(req_reg.position);
        cnt_x       = CMP_W'(count_reg);
        ins_x       = (req_reg.req_type == REQ_APPEND) ? cnt_x : pos_x;
        full        = (cnt_x >= CMP_W'(DEPTH));
        cmd         = '0;
        cmd_pos     = IDX_W'(pos_x);
        status_next = ST_OK;
        rd_next     = '0;
        count_next  = count_reg;
        case (req_reg.req_type)
            REQ_APPEND, REQ_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else if (ins_x > cnt_x)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    cmd.shift_up = exec_reg;
                    cmd_pos      = IDX_W'(ins_x);
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            REQ_DELETE:
            begin
                if (pos_x >= cnt_x)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    cmd.shift_down = exec_reg;
                    count_next     = count_reg - CNT_W'(1);
                end
            end
            REQ_READ:
            begin
                if (pos_x >= cnt_x)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    rd_next = ITEM_W'($signed(cell_value[IDX_W'(pos_x)]));
                end
            end
            REQ_FIND:
            begin
                // settled in the response cycle from the registered matches
                status_next = ST_NOT_FOUND;
            end
            default:
            begin
                status_next = ST_RANGE;
            end
        endcase
    end

    // response cycle: first matching slot below the count
    always_comb
    begin
        hit  = 1'b0;
        fpos = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (cell_match[i] && (CNT_W'(i) < count_reg))
            begin
                hit  = 1'b1;
                fpos = IDX_W'(i);
            end
        end
        result_next.status         = find_reg ? (hit ? ST_OK : ST_NOT_FOUND) : status_reg;
        result_next.read_value     = rd_reg;
        result_next.found_position = (find_reg && hit) ? FPOS_W'(fpos) : '0;
        result_next.entry_count    = CNT_OUT_W'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_reg  <= 1'b0;
            resp_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            exec_reg <= accept;
            resp_reg <= exec_reg;
            done_reg <= resp_reg;
            if (exec_reg)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (exec_reg)
        begin
            status_reg <= status_next;
            rd_reg     <= rd_next;
            find_reg   <= (req_reg.req_type == REQ_FIND);
        end
        if (resp_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = exec_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/ordered_list_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Bounded ordered list of signed values held in a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (append, insert, delete, read, find) is taken at a clock
//   edge where start is high and busy is low. Busy is high for the one
//   execute cycle that follows, while the cells shift or compare.
//   Exactly one result word comes back: done is high for one cycle and the
//   result port holds status, read value, found position and entry count.
//   The request passes the execute and response registers before done rises;
//   the result word is registered at the end of the response cycle and is
//   shown with done. The next request may be taken during the response cycle
//   of the one before; only the execute cycle of the cell chain holds it off.
//   The receiver cannot stall: done flags a result for one cycle only.
//   Reset empties the list (count zero) and drops any request in flight.
//   Slot contents are not reset; only slots below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_list_engine_top #(
    parameter int DEPTH       = olist_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = olist_pkg::VALUE_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  olist_pkg::request_t request,
    output logic                done,
    output olist_pkg::result_t  result
);

    import olist_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cell_cmd_t              cmd;
    logic [IDX_W-1:0]       cmd_pos;
    logic [VALUE_WIDTH-1:0] item;
    logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]       cell_match;

    olist_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .cmd        (cmd),
        .cmd_pos    (cmd_pos),
        .item       (item),
        .cell_value (cell_value),
        .cell_match (cell_match)
    );

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_value;
        logic [VALUE_WIDTH-1:0] right_value;

        // the end cells never use their outer neighbor
        if (g == 0)
        begin : g_first
            assign left_value = item;
        end
        else
        begin : g_inner_l
            assign left_value = cell_value[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_value = cell_value[g];
        end
        else
        begin : g_inner_r
            assign right_value = cell_value[g+1];
        end

        olist_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX_W       (IDX_W),
            .CELL_IDX    (g)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .pos         (cmd_pos),
            .item        (item),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[g]),
            .match       (cell_match[g])
        );
    end

endmodule

// ===== rtl/core/olist_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_checker
// Port-level checks on the request and result timing of the list engine.
// ----------------------------------------------------------------------------
module olist_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input olist_pkg::result_t result
);

    import olist_pkg::*;

    // an accepted word occupies exactly one execute cycle
    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy ##1 !busy)
        else $error("busy not high for exactly one cycle after accept");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result word missing three cycles after accept");

    // no result without an earlier execute cycle of a request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy, 2))
        else $error("result word without a request");

    a_fail_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_OK)) |->
            ((result.read_value == '0) && (result.found_position == '0)))
        else $error("failed request returned nonzero data");

endmodule

bind ordered_list_engine_top olist_checker u_olist_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
